// File: sv/stable_priority_queue_core_assert.svh
// Assertion macros for the stable priority queue core.
// Each macro names its check, samples on the rising edge of clk and is
// switched off while rst is high.
`ifndef STABLE_PRIORITY_QUEUE_CORE_ASSERT_SVH
`define STABLE_PRIORITY_QUEUE_CORE_ASSERT_SVH

// Same-cycle implication.
`define SPQ_ASSERT_NOW(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("spq check failed");

// Next-cycle implication.
`define SPQ_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("spq check failed");

`endif

// File: sv/spq_pkg.sv
package spq_pkg;

  localparam int ID_BITS       = 8;
  localparam int PRIORITY_BITS = 8;
  localparam int OCC_BITS      = 5;
  localparam int DEF_QUEUE_DEPTH = 16;

  localparam logic ACT_INSERT = 1'b0;
  localparam logic ACT_REMOVE = 1'b1;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } spq_status_t;

  typedef struct packed {
    logic                     action;
    logic [ID_BITS-1:0]       item_id;
    logic [PRIORITY_BITS-1:0] item_priority;
  } spq_req_t;

  typedef struct packed {
    logic                     out_valid;
    logic [ID_BITS-1:0]       out_id;
    logic [PRIORITY_BITS-1:0] out_priority;
    spq_status_t              status_code;
    logic [OCC_BITS-1:0]      occupancy;
  } spq_res_t;

  typedef struct packed {
    logic [ID_BITS-1:0]       id;
    logic [PRIORITY_BITS-1:0] pri;
  } spq_entry_t;

  // Broadcast to every cell in a cycle.
  typedef struct packed {
    logic       insert;
    logic       remove;
    spq_entry_t new_entry;
  } spq_cell_ctrl_t;

endpackage

// File: sv/spq_cell.sv
module spq_cell
  import spq_pkg::*;
(
  input  logic           clk,
  input  spq_cell_ctrl_t ctrl,
  input  logic           occ,
  input  logic           prev_ge,
  input  spq_entry_t     prev_entry,
  input  spq_entry_t     next_entry,
  output spq_entry_t     entry,
  output logic           ge
);

  spq_entry_t entry_next;

  // Keep the entry when it is at least as urgent as the newcomer.
  assign ge = occ && (entry.pri >= ctrl.new_entry.pri);

  always_comb begin
    entry_next = entry;
    if (ctrl.insert) begin
      if (!ge) begin
        entry_next = prev_ge ? ctrl.new_entry : prev_entry;
      end
    end else if (ctrl.remove) begin
      entry_next = next_entry;
    end
  end

  always_ff @(posedge clk) begin
    entry <= entry_next;
  end

endmodule

// File: sv/stable_priority_queue_core.sv
// Stable priority queue core.
// Request channel (in_valid, in_stall, in_req): action 0 inserts item_id at
// item_priority, action 1 removes the head. Result channel (res_valid,
// res_stall, res): one result per request with the removed entry, a status
// code (ok, empty on removal, full on a dropped insertion) and the number of
// entries held afterwards.
// Entries sit in a row of QUEUE_DEPTH cells, highest priority at cell 0 and
// first-in-first-out among equal priorities. Every cell compares its own
// priority with the incoming one in parallel, so an insertion or removal
// completes in the cycle the request is accepted.
// The result is registered and appears in the cycle after acceptance. One
// request per cycle while the result is not stalled; the result register lets
// the next request in while the previous result is being taken.
// A stalled result holds in its register and in_stall rises, so no further
// request enters until the result is taken.
// Reset empties the queue (count to zero) and drops any pending result;
// cell contents are not cleared.
module stable_priority_queue_core
  import spq_pkg::*;
#(
  parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_stall,
  input  spq_req_t in_req,
  output logic     res_valid,
  input  logic     res_stall,
  output spq_res_t res
);

  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;
  logic             res_valid_next;
  spq_res_t         res_next;

  spq_cell_ctrl_t   ctrl;
  spq_entry_t       cell_entry [QUEUE_DEPTH];
  logic             cell_ge    [QUEUE_DEPTH];

  logic accept;
  logic full;
  logic empty;

  // Hold requests only while a result waits and the receiver stalls.
  assign in_stall = res_valid && res_stall;
  assign accept   = in_valid && !in_stall;
  assign full     = (count == CNT_W'(QUEUE_DEPTH));
  assign empty    = (count == '0);

  // Drop inserts into a full queue and removals from an empty one.
  always_comb begin
    ctrl.insert        = accept && (in_req.action == ACT_INSERT) && !full;
    ctrl.remove        = accept && (in_req.action == ACT_REMOVE) && !empty;
    ctrl.new_entry.id  = in_req.item_id;
    ctrl.new_entry.pri = in_req.item_priority;
  end

  // The row of cells: each takes from its left neighbor on insert and from
  // its right neighbor on removal.
  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    logic       prev_ge;
    spq_entry_t prev_entry;
    spq_entry_t next_entry;

    if (i == 0) begin : g_head
      assign prev_ge    = 1'b1;
      assign prev_entry = ctrl.new_entry;
    end else begin : g_body
      assign prev_ge    = cell_ge[i-1];
      assign prev_entry = cell_entry[i-1];
    end

    if (i == QUEUE_DEPTH - 1) begin : g_tail
      assign next_entry = cell_entry[i];
    end else begin : g_mid
      assign next_entry = cell_entry[i+1];
    end

    spq_cell u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .occ        (count > CNT_W'(i)),
      .prev_ge    (prev_ge),
      .prev_entry (prev_entry),
      .next_entry (next_entry),
      .entry      (cell_entry[i]),
      .ge         (cell_ge[i])
    );
  end

  // Advance the entry count and build the result from the head cell.
  always_comb begin
    count_next     = count;
    res_valid_next = res_valid && res_stall;
    res_next       = res;
    if (ctrl.insert) begin
      count_next = count + 1'b1;
    end else if (ctrl.remove) begin
      count_next = count - 1'b1;
    end
    if (accept) begin
      res_valid_next        = 1'b1;
      res_next.out_valid    = ctrl.remove;
      res_next.out_id       = ctrl.remove ? cell_entry[0].id : '0;
      res_next.out_priority = ctrl.remove ? cell_entry[0].pri : '0;
      res_next.occupancy    = OCC_BITS'(count_next);
      if (in_req.action == ACT_INSERT) begin
        res_next.status_code = full ? ST_FULL : ST_OK;
      end else begin
        res_next.status_code = empty ? ST_EMPTY : ST_OK;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      res_valid <= 1'b0;
    end else begin
      count     <= count_next;
      res_valid <= res_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    res <= res_next;
  end

`include "stable_priority_queue_core_assert.svh"

  `SPQ_ASSERT_NOW(a_count_bound, 1'b1, count <= CNT_W'(QUEUE_DEPTH))
  `SPQ_ASSERT_NOW(a_stall_holds_req, res_valid && res_stall, in_stall)
  `SPQ_ASSERT_NEXT(a_remove_count, ctrl.remove, count == $past(count) - 1'b1)
  `SPQ_ASSERT_NEXT(a_full_drop, accept && (in_req.action == ACT_INSERT) && full,
                   res.status_code == ST_FULL && count == $past(count))

endmodule
